// ===== rtl/shared_exclusive_lock_table_macros.svh =====
// Assertion macros used by the lock table top level.
`ifndef SHARED_EXCLUSIVE_LOCK_TABLE_MACROS_SVH
`define SHARED_EXCLUSIVE_LOCK_TABLE_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define SEL_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define SEL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/sel_pkg.sv =====
// Package with request codes and the decoded request struct of the lock table.
`timescale 1ns / 1ps
`default_nettype none

package sel_pkg;

  typedef enum logic [2:0] {
    REQ_XLOCK     = 3'd0,
    REQ_SLOCK     = 3'd1,
    REQ_XUNLOCK   = 3'd2,
    REQ_SUNLOCK   = 3'd3,
    REQ_SLEEP     = 3'd4,
    REQ_HAS_LOCK  = 3'd5,
    REQ_HAS_XLOCK = 3'd6,
    REQ_HAS_SLOCK = 3'd7
  } req_e_t;

  typedef struct packed {
    req_e_t req;
    logic   ask;
    logic   var_ok;
    logic   txn_ok;
  } sel_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/sel_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps
`default_nettype none

module sel_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== rtl/sel_update.sv =====
// Read-modify-write logic that applies one request to one variable entry.
`timescale 1ns / 1ps
`default_nettype none

module sel_update #(
  parameter int NUM_TXNS = 16,
  localparam int CW = $clog2(NUM_TXNS + 1)
) (
  input  sel_pkg::sel_ctrl_t  ctrl_i,
  input  logic [NUM_TXNS-1:0] bit_i,
  input  logic                excl_i,
  input  logic [CW-1:0]       cnt_i,
  input  logic [NUM_TXNS-1:0] hold_i,
  input  logic [NUM_TXNS-1:0] sleep_i,
  output logic                excl_o,
  output logic [CW-1:0]       cnt_o,
  output logic [NUM_TXNS-1:0] hold_o,
  output logic [NUM_TXNS-1:0] sleep_o,
  output logic                ok_o,
  output logic [NUM_TXNS-1:0] wake_o,
  output logic [NUM_TXNS-1:0] set_o
);

  import sel_pkg::*;

  logic held;
  logic locked;

  assign held   = |(hold_i & bit_i);
  assign locked = |hold_i;

  always_comb begin
    excl_o  = excl_i;
    cnt_o   = cnt_i;
    hold_o  = hold_i;
    sleep_o = sleep_i;
    ok_o    = 1'b0;
    wake_o  = '0;
    set_o   = '0;
    if (!ctrl_i.var_ok) begin
      ok_o = (ctrl_i.req == REQ_XUNLOCK) || (ctrl_i.req == REQ_SUNLOCK) ||
             (ctrl_i.req == REQ_SLEEP);
    end else begin
      case (ctrl_i.req)
        REQ_XLOCK: begin
          if (!ctrl_i.txn_ok) begin
            ok_o = 1'b0;
          end else if (excl_i && held) begin
            ok_o = 1'b1;
          end else if (locked && (hold_i != bit_i)) begin
            ok_o = 1'b0;
          end else begin
            excl_o = 1'b1;
            cnt_o  = '0;
            hold_o = bit_i;
            ok_o   = 1'b1;
          end
        end
        REQ_SLOCK: begin
          if (!ctrl_i.txn_ok) begin
            ok_o = 1'b0;
          end else if (held) begin
            ok_o = 1'b1;
          end else if (excl_i) begin
            ok_o = 1'b0;
          end else begin
            cnt_o  = cnt_i + CW'(1);
            hold_o = hold_i | bit_i;
            ok_o   = 1'b1;
          end
        end
        REQ_XUNLOCK: begin
          excl_o  = 1'b0;
          cnt_o   = '0;
          hold_o  = '0;
          sleep_o = '0;
          wake_o  = sleep_i;
          ok_o    = 1'b1;
        end
        REQ_SUNLOCK: begin
          ok_o = 1'b1;
          if (ctrl_i.txn_ok && locked && !excl_i) begin
            if (cnt_i <= CW'(1)) begin
              excl_o = 1'b0;
              cnt_o  = '0;
              hold_o = '0;
            end else begin
              cnt_o  = cnt_i - CW'(1);
              hold_o = hold_i & ~bit_i;
            end
            sleep_o = '0;
            wake_o  = sleep_i;
          end
        end
        REQ_SLEEP: begin
          sleep_o = sleep_i | bit_i;
          set_o   = bit_i & ~sleep_i;
          ok_o    = 1'b1;
        end
        REQ_HAS_LOCK: begin
          ok_o = held;
        end
        REQ_HAS_XLOCK: begin
          ok_o = held && excl_i;
        end
        REQ_HAS_SLOCK: begin
          ok_o = !ctrl_i.ask && held && !excl_i;
        end
        default: begin
          ok_o = 1'b0;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/sel_sleep_trk.sv =====
// Per-transaction counters of the variables each transaction sleeps on.
`timescale 1ns / 1ps
`default_nettype none

module sel_sleep_trk #(
  parameter int NUM_VARS = 64,
  parameter int NUM_TXNS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [NUM_TXNS-1:0] set_i,
  input  logic [NUM_TXNS-1:0] wake_i,
  output logic [NUM_TXNS-1:0] sleeping_o
);

  localparam int SW = $clog2(NUM_VARS + 1);

  logic [SW-1:0] cnt_r [NUM_TXNS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_TXNS; i++) begin
        cnt_r[i] <= '0;
      end
    end else begin
      for (int i = 0; i < NUM_TXNS; i++) begin
        if (set_i[i]) begin
          cnt_r[i] <= cnt_r[i] + SW'(1);
        end else if (wake_i[i]) begin
          cnt_r[i] <= cnt_r[i] - SW'(1);
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_TXNS; i++) begin
      sleeping_o[i] = (cnt_r[i] != '0);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/shared_exclusive_lock_table.sv =====
// Top level of the shared/exclusive lock table.
//
//   Channel  | Ports                                                 | Handshake
//   request  | in_req_type, in_var_id, in_txn_id, in_ask_sleeping   | start & !busy
//   result   | out_ok                                                | out_valid
//
// One word is accepted per cycle while busy is low; its result passes the s2
// registers and the output register and shows for one cycle. The variable table
// is one RAM with a registered read; a read of an entry being written is forwarded.
// After reset a clearing pass writes zero to every entry, with busy high.
// The receiver cannot stall, so busy is only high during the clearing pass.
`timescale 1ns / 1ps
`default_nettype none
`include "shared_exclusive_lock_table_macros.svh"

module shared_exclusive_lock_table #(
  parameter int NUM_VARS = 64,
  parameter int NUM_TXNS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [2:0] in_req_type,
  input  logic [5:0] in_var_id,
  input  logic [3:0] in_txn_id,
  input  logic       in_ask_sleeping,
  output logic       out_valid,
  output logic       out_ok
);

  import sel_pkg::*;

  localparam int AW = (NUM_VARS > 1) ? $clog2(NUM_VARS) : 1;
  localparam int XW = (AW > 6) ? AW : 6;
  localparam int CW = $clog2(NUM_TXNS + 1);
  localparam int EW = 1 + CW + 2 * NUM_TXNS;

  logic              accept;
  logic [XW-1:0]     in_addr_ext;
  logic [AW-1:0]     in_addr;

  logic              clearing_r;
  logic [AW-1:0]     clr_addr_r;

  logic              s2_valid_r;
  logic [2:0]        s2_req_r;
  logic [5:0]        s2_var_r;
  logic [3:0]        s2_txn_r;
  logic              s2_ask_r;
  logic [AW-1:0]     s2_addr_r;
  logic              fwd_r;
  logic [EW-1:0]     fwd_data_r;

  logic              out_valid_r;
  logic              out_ok_r;

  sel_ctrl_t         ctrl;
  logic [NUM_TXNS-1:0] txn_bit;
  logic [EW-1:0]     ram_rdata;
  logic [EW-1:0]     entry;
  logic [EW-1:0]     entry_new;
  logic              s2_we;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [EW-1:0]     ram_wdata;

  logic                excl_o;
  logic [CW-1:0]       cnt_o;
  logic [NUM_TXNS-1:0] hold_o;
  logic [NUM_TXNS-1:0] sleep_o;
  logic                upd_ok;
  logic [NUM_TXNS-1:0] wake_mask;
  logic [NUM_TXNS-1:0] set_mask;
  logic [NUM_TXNS-1:0] sleeping;
  logic                sleep_query;
  logic                ok_nxt;

  assign busy        = clearing_r;
  assign accept      = start && !busy;
  assign in_addr_ext = XW'(in_var_id);
  assign in_addr     = in_addr_ext[AW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clearing_r) begin
      clr_addr_r <= clr_addr_r + AW'(1);
      if (clr_addr_r == AW'(NUM_VARS - 1)) begin
        clearing_r <= 1'b0;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_TXNS; i++) begin
      txn_bit[i] = (int'(s2_txn_r) == i);
    end
  end

  assign ctrl.req    = req_e_t'(s2_req_r);
  assign ctrl.ask    = s2_ask_r;
  assign ctrl.var_ok = (int'(s2_var_r) < NUM_VARS);
  assign ctrl.txn_ok = |txn_bit;

  assign entry     = fwd_r ? fwd_data_r : ram_rdata;
  assign entry_new = {excl_o, cnt_o, hold_o, sleep_o};
  assign s2_we     = s2_valid_r && ctrl.var_ok;

  assign ram_we    = clearing_r || s2_we;
  assign ram_waddr = clearing_r ? clr_addr_r : s2_addr_r;
  assign ram_wdata = clearing_r ? '0 : entry_new;

  sel_ram #(
    .WIDTH (EW),
    .DEPTH (NUM_VARS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (in_addr),
    .rdata (ram_rdata)
  );

  sel_update #(
    .NUM_TXNS (NUM_TXNS)
  ) u_update (
    .ctrl_i  (ctrl),
    .bit_i   (txn_bit),
    .excl_i  (entry[EW-1]),
    .cnt_i   (entry[EW-2 -: CW]),
    .hold_i  (entry[2*NUM_TXNS-1 -: NUM_TXNS]),
    .sleep_i (entry[NUM_TXNS-1:0]),
    .excl_o  (excl_o),
    .cnt_o   (cnt_o),
    .hold_o  (hold_o),
    .sleep_o (sleep_o),
    .ok_o    (upd_ok),
    .wake_o  (wake_mask),
    .set_o   (set_mask)
  );

  sel_sleep_trk #(
    .NUM_VARS (NUM_VARS),
    .NUM_TXNS (NUM_TXNS)
  ) u_sleep_trk (
    .clk        (clk),
    .rst_n      (rst_n),
    .set_i      (s2_valid_r ? set_mask : '0),
    .wake_i     (s2_valid_r ? wake_mask : '0),
    .sleeping_o (sleeping)
  );

  assign sleep_query = (ctrl.req == REQ_HAS_SLOCK) && s2_ask_r;
  assign ok_nxt      = sleep_query ? |(sleeping & txn_bit) : upd_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r  <= 1'b0;
      fwd_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s2_valid_r  <= accept;
      fwd_r       <= accept && s2_we && (in_addr == s2_addr_r);
      out_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s2_req_r  <= in_req_type;
      s2_var_r  <= in_var_id;
      s2_txn_r  <= in_txn_id;
      s2_ask_r  <= in_ask_sleeping;
      s2_addr_r <= in_addr;
    end
    fwd_data_r <= entry_new;
    out_ok_r   <= ok_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_ok    = out_ok_r;

  `SEL_ASSERT_NEXT(a_accept_enters_stage, clk, rst_n, accept, s2_valid_r, "accepted word lost")
  `SEL_ASSERT_NEXT(a_stage_gives_result, clk, rst_n, s2_valid_r, out_valid_r, "result dropped")
  `SEL_ASSERT_SAME(a_no_work_while_clearing, clk, rst_n, clearing_r, !s2_valid_r && !fwd_r, "request in flight during clearing pass")

endmodule

`default_nettype wire
